// ===== src/ofd_pkg.sv =====
// Package with the shared types and constants of the option fingerprint de-duplication block.
`timescale 1ns / 1ps

package ofd_pkg;

  // Fingerprint table geometry.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Lookup status codes.
  localparam logic [1:0] ST_NEW  = 2'd0;
  localparam logic [1:0] ST_SEEN = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_SKIP_A = 8'd0;
  localparam logic [7:0] CFG_SKIP_B = 8'd1;
  localparam logic [7:0] CFG_SKIP_C = 8'd2;
  localparam logic [7:0] CFG_SKIP_D = 8'd3;

  // Reset values of the skip codes.
  localparam logic [7:0] SKIP_A_RST = 8'd2;
  localparam logic [7:0] SKIP_B_RST = 8'd51;
  localparam logic [7:0] SKIP_C_RST = 8'd58;
  localparam logic [7:0] SKIP_D_RST = 8'd59;

  // Input item.
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       end_of_packet;
  } ofd_in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]  lookup_status;
    logic [7:0]  entry_index;
    logic [31:0] fingerprint;
  } ofd_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_en;
    logic fp_load;
    logic rd_en;
    logic idx_inc;
    logic load_seen;
    logic load_nf;
  } ofd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic match;
    logic last;
  } ofd_sts_t;

endpackage

// ===== src/ofd_dp.sv =====
// Datapath: option record parser, packet sums, fingerprint table and result register.
`timescale 1ns / 1ps

module ofd_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ofd_pkg::ofd_cmd_t cmd_i,
  output ofd_pkg::ofd_sts_t sts_o,
  input  ofd_pkg::ofd_in_t  in_data_i,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  output ofd_pkg::ofd_out_t out_data_o
);
  import ofd_pkg::*;

  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  logic [7:0]  skip_a_q, skip_b_q, skip_c_q, skip_d_q;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  rem_q, rem_d;
  logic [8:0]  off_q, off_d;
  logic [31:0] rw_q, rw_d;
  logic [15:0] rp_q, rp_d;
  logic [31:0] pw_q, pw_d;
  logic [15:0] pp_q, pp_d;
  logic [16:0] prod;
  logic        fin;
  logic        skip;
  logic [7:0]  b;

  logic [31:0]      fp_q;
  logic [IDX_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      rdata_q;
  logic [31:0]      mem_q [TABLE_DEPTH];
  logic             full;
  ofd_out_t         out_q;

  assign b = in_data_i.opt_byte;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_a_q <= SKIP_A_RST;
      skip_b_q <= SKIP_B_RST;
      skip_c_q <= SKIP_C_RST;
      skip_d_q <= SKIP_D_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SKIP_A: skip_a_q <= cfg_data_i;
        CFG_SKIP_B: skip_b_q <= cfg_data_i;
        CFG_SKIP_C: skip_c_q <= cfg_data_i;
        CFG_SKIP_D: skip_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Record parser: next values for one byte.
  always_comb begin
    prod  = 17'(b) * 17'(off_q);
    skip  = (code_q == skip_a_q) || (code_q == skip_b_q) ||
            (code_q == skip_c_q) || (code_q == skip_d_q);
    code_d  = code_q;
    rem_d   = rem_q;
    rw_d    = rw_q + 32'(prod);
    rp_d    = rp_q + 16'(b);
    off_d   = off_q + 9'd1;
    phase_d = phase_q;
    fin     = 1'b0;
    case (phase_q)
      PH_CODE: begin
        code_d  = b;
        rw_d    = '0;
        rp_d    = 16'(b);
        off_d   = 9'd1;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        rem_d   = b;
        fin     = (b == 8'd0);
        phase_d = fin ? PH_CODE : PH_VALUE;
      end
      default: begin
        rem_d   = rem_q - 8'd1;
        fin     = (rem_d == 8'd0);
        phase_d = fin ? PH_CODE : PH_VALUE;
      end
    endcase
    pw_d = pw_q;
    pp_d = pp_q;
    if (fin && !skip) begin
      pw_d = pw_q + rw_d;
      pp_d = pp_q + rp_d;
    end
  end

  // Parser and packet sum registers; cleared once the fingerprint is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      code_q  <= '0;
      rem_q   <= '0;
      off_q   <= '0;
      rw_q    <= '0;
      rp_q    <= '0;
      pw_q    <= '0;
      pp_q    <= '0;
    end else if (cmd_i.fp_load) begin
      phase_q <= PH_CODE;
      code_q  <= '0;
      rem_q   <= '0;
      off_q   <= '0;
      rw_q    <= '0;
      rp_q    <= '0;
      pw_q    <= '0;
      pp_q    <= '0;
    end else if (cmd_i.byte_en) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      rw_q    <= rw_d;
      rp_q    <= rp_d;
      pw_q    <= pw_d;
      pp_q    <= pp_d;
    end
  end

  // Fingerprint register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fp_load) begin
      fp_q <= pw_q + {pp_q, 16'h0000};
    end
  end

  // Search index and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.fp_load) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.load_nf && !full) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign full = (cnt_q == CNT_W'(TABLE_DEPTH));

  // Fingerprint table, one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_nf && !full) begin
      mem_q[cnt_q[IDX_W-1:0]] <= fp_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.match    = (rdata_q == fp_q);
  assign sts_o.last     = ((CNT_W'(idx_q) + 1'b1) == cnt_q);

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seen) begin
      out_q.lookup_status <= ST_SEEN;
      out_q.entry_index   <= 8'(idx_q);
      out_q.fingerprint   <= fp_q;
    end else if (cmd_i.load_nf) begin
      out_q.lookup_status <= full ? ST_FULL : ST_NEW;
      out_q.entry_index   <= full ? 8'd0 : 8'(cnt_q[IDX_W-1:0]);
      out_q.fingerprint   <= fp_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== src/ofd_ctrl.sv =====
// Controller: state machine that sequences byte intake, table search and result hand-off.
`timescale 1ns / 1ps

module ofd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_eop_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  ofd_pkg::ofd_sts_t sts_i,
  output ofd_pkg::ofd_cmd_t cmd_o
);
  import ofd_pkg::*;

  typedef enum logic [4:0] {
    S_IN  = 5'b00001,
    S_FP  = 5'b00010,
    S_RD  = 5'b00100,
    S_CMP = 5'b01000,
    S_INS = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // A final byte waits until the result register is free.
  assign in_ready_o = (state_q == S_IN) && !(out_valid_q && in_eop_i);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IN: begin
        cmd_o.byte_en = accept;
        if (accept && in_eop_i) begin
          state_d = S_FP;
        end
      end
      S_FP: begin
        cmd_o.fp_load = 1'b1;
        state_d = sts_i.cnt_zero ? S_INS : S_RD;
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.match) begin
          cmd_o.load_seen = 1'b1;
          state_d = S_IN;
        end else if (sts_i.last) begin
          state_d = S_INS;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_RD;
        end
      end
      S_INS: begin
        cmd_o.load_nf = 1'b1;
        state_d = S_IN;
      end
      default: begin
        state_d = S_IN;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_seen || cmd_o.load_nf) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/option_fingerprint_dedup.sv =====
// Bytes that do not end a packet are taken one per cycle, back to back, while no search runs.
// After the final byte the fingerprint is formed, then stored entries are read and compared.
// The result is made valid on a match at the k-th entry, or once all k stored entries miss
// (k from 0 to TABLE_DEPTH). No byte is taken during a search; while a result waits,
// later bytes of a packet go in, but its final byte waits. Reset (rst_ni low, async)
// clears parser, count and result valid and restores the reset skip codes; table is kept.
`timescale 1ns / 1ps

module option_fingerprint_dedup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ofd_pkg::ofd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ofd_pkg::ofd_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import ofd_pkg::*;

  ofd_cmd_t cmd;
  ofd_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  ofd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_eop_i   (in_data_i.end_of_packet),
    .in_ready_o (in_ready_o),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ofd_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

  // Only one datapath action at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.byte_en, cmd.fp_load, cmd.rd_en, cmd.idx_inc, cmd.load_seen, cmd.load_nf}))
    else $error("conflicting datapath commands");

  // A final byte is never taken while a result is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_data_i.end_of_packet) |-> !in_ready_o)
    else $error("final byte accepted over a pending result");

  // A seen result is reported only on a real match of a read entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_seen |-> (sts.match && $past(cmd.rd_en)))
    else $error("seen result without a matching table read");

  // A new result appears only after a result load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_seen || cmd.load_nf))
    else $error("result valid without a result load");

endmodule

// ===== tb/tb_option_fingerprint_dedup.sv =====
// Self-checking testbench for the option fingerprint de-duplication block.
`timescale 1ns / 1ps

module tb_option_fingerprint_dedup;
  import ofd_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Longest table search over a full table, plus margin.
  localparam int SEARCH_SETTLE = 600;
  // Bytes of random packets per idling phase.
  localparam int PHASE_BYTES = 20;

  // Option parser position.
  typedef enum logic [1:0] {
    PS_CODE,
    PS_LEN,
    PS_VALUE
  } parse_state_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  ofd_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  ofd_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  // Stimulus and expectation stores.
  ofd_in_t    option_bytes[$];
  ofd_out_t   expected_lookups[$];
  logic [7:0] packet_history[$];
  int         history_start[$];
  int         history_len[$];
  int         bytes_queued = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Predictor state: skip codes, parser, packet sums and fingerprint table.
  logic [7:0]   skip_codes [4];
  parse_state_e parse_state = PS_CODE;
  logic [7:0]   rec_code = '0;
  logic [7:0]   rec_left = '0;
  logic [8:0]   rec_pos = '0;
  logic [31:0]  rec_wsum = '0;
  logic [15:0]  rec_psum = '0;
  logic [31:0]  pkt_wsum = '0;
  logic [15:0]  pkt_psum = '0;
  logic [31:0]  fp_table [TABLE_DEPTH];
  int           fp_count = 0;

  option_fingerprint_dedup dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock generation.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic is_skip(input logic [7:0] code);
    return (code == skip_codes[0]) || (code == skip_codes[1]) ||
           (code == skip_codes[2]) || (code == skip_codes[3]);
  endfunction

  // Add one byte to the running record sums, weighted by its record offset.
  function automatic void accumulate(input logic [7:0] b);
    rec_wsum = rec_wsum + b * rec_pos;
    rec_psum = rec_psum + b;
    rec_pos  = rec_pos + 1'b1;
  endfunction

  // A complete record counts toward the packet unless its code is skipped.
  function automatic void close_record();
    if (!is_skip(rec_code)) begin
      pkt_wsum = pkt_wsum + rec_wsum;
      pkt_psum = pkt_psum + rec_psum;
    end
    parse_state = PS_CODE;
  endfunction

  // Advance the parser by one accepted item; on packet end, look up the table.
  function automatic void parse_option_byte(input ofd_in_t item);
    logic [7:0]  b;
    logic [31:0] fprint;
    logic        hit;
    int          slot;
    ofd_out_t    lookup;
    b = item.opt_byte;
    case (parse_state)
      PS_CODE: begin
        rec_code = b;
        rec_wsum = '0;
        rec_psum = '0;
        rec_pos  = '0;
        accumulate(b);
        parse_state = PS_LEN;
      end
      PS_LEN: begin
        rec_left = b;
        accumulate(b);
        if (b == 8'd0) close_record();
        else parse_state = PS_VALUE;
      end
      default: begin
        accumulate(b);
        rec_left = rec_left - 1'b1;
        if (rec_left == 8'd0) close_record();
      end
    endcase
    if (item.end_of_packet) begin
      fprint = pkt_wsum + {pkt_psum, 16'h0000};
      hit = 1'b0;
      slot = 0;
      for (int i = 0; i < fp_count; i++) begin
        if (!hit && fp_table[i] == fprint) begin
          hit = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        lookup.lookup_status = ST_SEEN;
      end else if (fp_count < int'(TABLE_DEPTH)) begin
        fp_table[fp_count] = fprint;
        slot = fp_count;
        fp_count++;
        lookup.lookup_status = ST_NEW;
      end else begin
        lookup.lookup_status = ST_FULL;
        slot = 0;
      end
      lookup.entry_index = slot[7:0];
      lookup.fingerprint = fprint;
      expected_lookups.push_back(lookup);
      // The parser and packet sums start over for the next packet.
      parse_state = PS_CODE;
      rec_code = '0;
      rec_left = '0;
      rec_pos  = '0;
      rec_wsum = '0;
      rec_psum = '0;
      pkt_wsum = '0;
      pkt_psum = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eop);
    ofd_in_t item;
    item.opt_byte = b;
    item.end_of_packet = eop;
    option_bytes.push_back(item);
    bytes_queued++;
  endtask

  // Codes hit the current skip codes about a quarter of the time.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) < 25) return skip_codes[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  // Mostly short records, a few medium ones and rarely a very long one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(4);
    if (r < 99) return $urandom_range(5, 24);
    return $urandom_range(200, 255);
  endfunction

  function automatic bit hist_ok();
    return history_start.size() != 0;
  endfunction

  // One packet: well-formed records, then maybe a cut-off tail or a lone code,
  // or a replay of an earlier packet to provoke a table hit.
  task automatic gen_packet(input bit force_replay);
    logic [7:0] pkt[$];
    int n_rec, len, pick, cut, shape, r, i;
    len = 0;
    if (hist_ok() && (force_replay || $urandom_range(99) < 15)) begin
      pick = $urandom_range(history_start.size() - 1);
      for (i = 0; i < history_len[pick]; i++)
        pkt.push_back(packet_history[history_start[pick] + i]);
    end else begin
      n_rec = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 3);
      for (r = 0; r < n_rec; r++) begin
        pkt.push_back(pick_code());
        len = pick_len();
        pkt.push_back(8'(len));
        for (i = 0; i < len; i++) pkt.push_back(8'($urandom_range(255)));
      end
      shape = $urandom_range(99);
      if (shape < 15 && n_rec > 0) begin
        cut = $urandom_range(1, len + 1);
        repeat (cut) void'(pkt.pop_back());
      end else if (shape < 27 || pkt.size() == 0) begin
        pkt.push_back(pick_code());
      end
      history_start.push_back(packet_history.size());
      history_len.push_back(pkt.size());
      foreach (pkt[k]) packet_history.push_back(pkt[k]);
    end
    foreach (pkt[k]) push_byte(pkt[k], k == pkt.size() - 1);
  endtask

  task automatic write_skip(input logic [7:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    skip_codes[idx] = value;
  endtask

  task automatic load_skip_codes(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c, input logic [7:0] d);
    write_skip(CFG_SKIP_A, a);
    write_skip(CFG_SKIP_B, b);
    write_skip(CFG_SKIP_C, c);
    write_skip(CFG_SKIP_D, d);
  endtask

  // Wait until every queued item went in and every lookup came back.
  task automatic drain_and_settle(input int settle);
    while (option_bytes.size() != 0 || in_valid_i || expected_lookups.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Input driver: presents the next queued item once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) parse_option_byte(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (option_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= option_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each lookup with the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    ofd_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.fingerprint, '0);
        end else begin
          want = expected_lookups.pop_front();
          if (out_data_o.lookup_status !== want.lookup_status)
            report_mismatch("lookup_status", 32'(out_data_o.lookup_status),
                            32'(want.lookup_status));
          if (out_data_o.entry_index !== want.entry_index)
            report_mismatch("entry_index", 32'(out_data_o.entry_index),
                            32'(want.entry_index));
          if (out_data_o.fingerprint !== want.fingerprint)
            report_mismatch("fingerprint", out_data_o.fingerprint, want.fingerprint);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_option_fingerprint_dedup failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int needed, i, phase, target, sweep;
    logic [7:0] code;
    skip_codes[0] = SKIP_A_RST;
    skip_codes[1] = SKIP_B_RST;
    skip_codes[2] = SKIP_C_RST;
    skip_codes[3] = SKIP_D_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed packets under the reset skip codes.
    // Zero-length record, then a record that ends on the last byte.
    push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b1);
    // Skipped lease-time record, then a zero-length record on the last byte.
    push_byte(8'd51, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'h00, 1'b1);
    // Record cut off by the end of the packet.
    push_byte(8'h07, 1'b0); push_byte(8'h05, 1'b0);
    push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b1);
    // Complete record followed by a lone final code byte.
    push_byte(8'h0C, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h2B, 1'b1);
    // Single-byte packet, same empty fingerprint as the cut-off one.
    push_byte(8'h80, 1'b1);
    // The first packet again: a table hit at slot zero.
    push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b1);
    drain_and_settle(8);

    // Random packets over three idling phases, each with its own skip codes.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          recv_stall_pct = 52;
          load_skip_codes(8'd0, 8'd255, 8'd1, 8'd254);
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 21;
          load_skip_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          load_skip_codes(SKIP_A_RST, SKIP_B_RST, SKIP_C_RST, SKIP_D_RST);
        end
      endcase
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) gen_packet(1'b0);
      drain_and_settle(8);
    end

    // Fill the table, mostly with two-byte packets of one zero-length record
    // whose fingerprint is the code shifted left by 16, then run past full.
    needed = int'(TABLE_DEPTH) - fp_count + 12;
    sweep = 1;
    for (i = 0; i < needed; i++) begin
      while (sweep < 256 && is_skip(8'(sweep))) sweep++;
      if (sweep < 256) begin
        push_byte(8'(sweep), 1'b0);
        push_byte(8'h00, 1'b1);
        sweep++;
      end else begin
        code = 8'($urandom_range(255));
        while (is_skip(code)) code = 8'($urandom_range(255));
        push_byte(code, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'($urandom_range(255)), 1'b1);
      end
    end
    for (i = 0; i < 4; i++) gen_packet(i[0] == 1'b0);
    drain_and_settle(SEARCH_SETTLE);

    if (mismatch_count == 0) begin
      $display("tb_option_fingerprint_dedup passed");
    end else begin
      $display("tb_option_fingerprint_dedup failed");
    end
    $finish;
  end

endmodule
